// ===== src/vwql_pkg.sv =====
// Package for the vertex weld lookup: sizes, shared types and controller states.
// No dependencies; imported by every module of the block.
`default_nettype none
package vwql_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 24;
	localparam int COORD_W     = 32;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [COORD_W-1:0] INV_RESET = 32'd65536000;
	localparam logic [IDX_W-1:0]   IDX_MAX   = {IDX_W{1'b1}};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} key3_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] canon;
	} tok_t;

	typedef struct packed {
		logic clr;
		logic wr;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUANT,
		ST_SCAN,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== src/vwql_quant.sv =====
// Grid quantizer: signed Q16.16 coordinate times unsigned Q16.16 reciprocal,
// rounded half away from zero and saturated to signed 32 bits. Uses vwql_pkg.
`default_nettype none
module vwql_quant import vwql_pkg::*; (
	input  logic               clk,
	input  logic [COORD_W-1:0] pos,
	input  logic [COORD_W-1:0] inv,
	output logic [COORD_W-1:0] key
);
	logic                 neg;
	logic [COORD_W-1:0]   mag;
	logic [2*COORD_W-1:0] prod_s1;
	logic                 neg_s1;
	logic [2*COORD_W-1:0] rnd;
	logic [COORD_W-1:0]   q;
	logic [COORD_W-1:0]   qs;

	assign neg = pos[COORD_W-1];
	assign mag = neg ? (~pos + 1'b1) : pos;

	always_ff @(posedge clk) begin
		prod_s1 <= {{COORD_W{1'b0}}, mag} * {{COORD_W{1'b0}}, inv};
		neg_s1  <= neg;
	end

	assign rnd = prod_s1 + {{COORD_W{1'b0}}, 1'b1, {(COORD_W-1){1'b0}}};
	assign q   = rnd[2*COORD_W-1:COORD_W];

	always_comb begin
		if (!neg_s1) begin
			qs  = '0;
			key = q[COORD_W-1] ? {1'b0, {(COORD_W-1){1'b1}}} : q;
		end else begin
			qs  = (q > {1'b1, {(COORD_W-1){1'b0}}}) ? {1'b1, {(COORD_W-1){1'b0}}} : q;
			key = ~qs + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== src/vwql_cell.sv =====
// One table slot of the key chain: holds a key triple and its first index,
// compares against the query and passes the search token on. Uses vwql_pkg.
`default_nettype none
module vwql_cell import vwql_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  key3_t            query,
	input  logic [IDX_W-1:0] wr_index,
	input  tok_t             tok_in,
	output tok_t             tok_out
);
	logic             valid_q;
	key3_t            key_q;
	logic [IDX_W-1:0] idx_q;
	tok_t             tok_q;
	logic             match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			key_q <= query;
			idx_q <= wr_index;
		end
	end

	assign match = valid_q && (key_q == query);

	always_ff @(posedge clk) begin
		if (!tok_in.found && match) begin
			tok_q <= '{found: 1'b1, canon: idx_q};
		end else begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
endmodule
`default_nettype wire

// ===== src/vertex_weld_quantized_lookup.sv =====
// Top level of the vertex weld lookup: controller, counters, output register
// and the row of vwql_cell slots. Uses vwql_pkg, vwql_quant, vwql_cell.
// Steps from one acceptance to the next: the three coordinates pass in turn through the
// shared quantizer multiplier, then the search token walks the whole cell chain, one slot
// per cycle, then the result is posted and a new key inserted once the output register is
// free, then the next vertex is taken in ST_IDLE. A finished result waits in the output
// register while the next vertex is taken. The table needs no clearing pass: slot valid
// bits clear together at reset and when a vertex with first_vertex set is accepted.
// inv_tolerance may be written whenever the block is idle.
`default_nettype none
module vertex_weld_quantized_lookup import vwql_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [COORD_W-1:0] pos_z,
	input  logic               first_vertex,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   vertex_index,
	output logic [IDX_W-1:0]   canonical_index,
	output logic               is_new,
	output logic [CNT_W-1:0]   unique_count,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COORD_W-1:0] cfg_data
);
	state_t             state_q, state_d;
	logic [1:0]         qcnt_q;
	logic [SLOT_W-1:0]  scnt_q;
	logic [COORD_W-1:0] inv_tol_q;
	logic [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	key3_t              key_q;
	logic [IDX_W-1:0]   my_index_q;
	logic               idx_ovf_q;
	logic [IDX_W-1:0]   vcount_q;
	logic [CNT_W-1:0]   ecount_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   vertex_index_q, canonical_index_q;
	logic               is_new_q, overflow_q;
	logic [CNT_W-1:0]   unique_count_q;

	logic               accept, finish, out_free, full, insert;
	logic [IDX_W-1:0]   my_idx;
	logic               my_ovf;
	logic [COORD_W-1:0] qpos, qkey;
	tok_t               tok [TABLE_DEPTH+1];
	tok_t               tail;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_QUANT;
			ST_QUANT: if (qcnt_q == 2'd3) state_d = ST_SCAN;
			ST_SCAN:  if (scnt_q == SLOT_W'(TABLE_DEPTH - 1)) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		accept   = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			ST_DONE: finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			qcnt_q  <= '0;
			scnt_q  <= '0;
		end else begin
			state_q <= state_d;
			qcnt_q  <= (state_q == ST_QUANT) ? qcnt_q + 2'd1 : 2'd0;
			scnt_q  <= (state_q == ST_SCAN) ? scnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tol_q <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_tol_q <= cfg_data;
		end
	end

	// vertex numbering and fill count
	assign my_idx = first_vertex ? '0 : vcount_q;
	assign my_ovf = (my_idx == IDX_MAX);
	assign tail   = tok[TABLE_DEPTH];
	assign full   = (ecount_q == CNT_W'(TABLE_DEPTH));
	assign insert = finish && !tail.found && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ecount_q <= '0;
		end else begin
			if (accept) begin
				vcount_q <= my_ovf ? my_idx : my_idx + 1'b1;
			end
			if (accept && first_vertex) begin
				ecount_q <= '0;
			end else if (insert) begin
				ecount_q <= ecount_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q    <= pos_x;
			pos_y_q    <= pos_y;
			pos_z_q    <= pos_z;
			my_index_q <= my_idx;
			idx_ovf_q  <= my_ovf;
		end
	end

	// one multiplier, one coordinate per cycle; each key leaves it in the following cycle
	always_comb begin
		case (qcnt_q)
			2'd0:    qpos = pos_x_q;
			2'd1:    qpos = pos_y_q;
			default: qpos = pos_z_q;
		endcase
	end

	vwql_quant u_quant (
		.clk (clk),
		.pos (qpos),
		.inv (inv_tol_q),
		.key (qkey)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_QUANT) begin
			case (qcnt_q)
				2'd1:    key_q.x <= qkey;
				2'd2:    key_q.y <= qkey;
				2'd3:    key_q.z <= qkey;
				default: ;
			endcase
		end
	end

	assign tok[0] = '{found: 1'b0, canon: '0};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.clr = accept && first_vertex;
		assign ctl.wr  = insert && (ecount_q[SLOT_W-1:0] == SLOT_W'(i));
		vwql_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.query    (key_q),
			.wr_index (my_index_q),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			vertex_index_q    <= my_index_q;
			canonical_index_q <= tail.found ? tail.canon : my_index_q;
			is_new_q          <= !tail.found;
			unique_count_q    <= insert ? ecount_q + 1'b1 : ecount_q;
			overflow_q        <= idx_ovf_q || (!tail.found && full);
		end
	end

	assign out_valid       = out_valid_q;
	assign vertex_index    = vertex_index_q;
	assign canonical_index = canonical_index_q;
	assign is_new          = is_new_q;
	assign unique_count    = unique_count_q;
	assign overflow        = overflow_q;
endmodule
`default_nettype wire

// ===== src/vwql_checker.sv =====
// Port-level checks for the vertex weld lookup, bound to the top level.
// Uses vwql_pkg; attaches to vertex_weld_quantized_lookup.
`default_nettype none
module vwql_checker import vwql_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [IDX_W-1:0]   vertex_index,
	input logic [IDX_W-1:0]   canonical_index,
	input logic               is_new,
	input logic [CNT_W-1:0]   unique_count,
	input logic               overflow
);
	// one vertex in flight: an accepted transaction blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(canonical_index) &&
		$stable(vertex_index) && $stable(is_new) && $stable(unique_count) &&
		$stable(overflow))
		else $error("stalled result changed");

	a_new_is_self: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new |-> canonical_index == vertex_index)
		else $error("new key not mapped to own index");

	a_hit_earlier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_new |-> canonical_index <= vertex_index && unique_count != '0)
		else $error("hit points past current vertex");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unique_count <= CNT_W'(TABLE_DEPTH))
		else $error("unique count beyond table depth");
endmodule

bind vertex_weld_quantized_lookup vwql_checker u_vwql_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.vertex_index    (vertex_index),
	.canonical_index (canonical_index),
	.is_new          (is_new),
	.unique_count    (unique_count),
	.overflow        (overflow)
);
`default_nettype wire
